>>> rtl/core/scdf_pkg.sv
// package of the shore chamfer distance field: defaults, register indexes, neighbour table
package scdf_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int FRAC_BITS_DEF  = 8;

  // reset values of the registers
  localparam logic [8:0]  GRID_WIDTH_RST  = 9'd256;
  localparam logic [7:0]  GRID_HEIGHT_RST = 8'd128;
  localparam logic [7:0]  THRESHOLD_RST   = 8'd8;
  localparam logic [15:0] SCALE_RST       = 16'd256;

  localparam int OUT_W = 25;

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_SCALE       = 2'd3
  } reg_idx_t;

  // neighbour offset along one axis
  typedef enum logic [1:0] {
    OFF_NEG  = 2'd0,
    OFF_ZERO = 2'd1,
    OFF_POS  = 2'd2
  } offset_t;

  typedef struct packed {
    offset_t dx;
    offset_t dy;
  } nb_off_t;

  // visiting order of the 3x3 window, centre last
  function automatic nb_off_t nb_offset(input logic [3:0] k);
    nb_off_t o;
    case (k)
      4'd0:    o = '{dx: OFF_NEG,  dy: OFF_NEG};
      4'd1:    o = '{dx: OFF_ZERO, dy: OFF_NEG};
      4'd2:    o = '{dx: OFF_POS,  dy: OFF_NEG};
      4'd3:    o = '{dx: OFF_NEG,  dy: OFF_ZERO};
      4'd4:    o = '{dx: OFF_POS,  dy: OFF_ZERO};
      4'd5:    o = '{dx: OFF_NEG,  dy: OFF_POS};
      4'd6:    o = '{dx: OFF_ZERO, dy: OFF_POS};
      4'd7:    o = '{dx: OFF_POS,  dy: OFF_POS};
      default: o = '{dx: OFF_ZERO, dy: OFF_ZERO};
    endcase
    return o;
  endfunction

endpackage

>>> rtl/core/shore_chamfer_distance_field.sv
// shore chamfer distance field: mask load, chamfer relaxation in memory, scaled readout
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+------------------------------
//  input   | in_action, in_mask_value, in_load_last        | start && !busy
//  result  | out_shore_distance, out_water_flag, out_read_last | out_strobe, one cycle
//  config  | psel, penable, pwrite, paddr, pwdata, prdata  | apb, pready always high
//
// loads and reads take one word per cycle while not busy; reads are registered in memory,
// then on out_*. a load word flagged last starts the relaxation: busy for an init pass plus
// up to (width+height) passes of 9 reads of the single read port and 1 write per pixel.
// reset is synchronous and clears control state only; the memories hold no reset value.
// the receiver cannot stall: results are dropped onto out_* with out_strobe for one cycle.
module shore_chamfer_distance_field #(
  parameter int MAX_WIDTH  = scdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = scdf_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = scdf_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [7:0]                in_mask_value,
  input  logic                      in_load_last,
  output logic                      out_strobe,
  output logic [scdf_pkg::OUT_W-1:0] out_shore_distance,
  output logic                      out_water_flag,
  output logic                      out_read_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import scdf_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 1);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = $clog2(MAX_WIDTH + MAX_HEIGHT + 1);
  localparam int DW = $clog2(((MAX_WIDTH + MAX_HEIGHT) << FRAC_BITS) + 1);
  localparam int PW = DW + 16;
  localparam longint DIAG_L =
    (longint'(141421356) * (longint'(1) << FRAC_BITS) + longint'(50000000)) / 100000000;
  localparam logic [DW:0] STEP_AX = (DW + 1)'(longint'(1) << FRAC_BITS);
  localparam logic [DW:0] STEP_DG = (DW + 1)'(DIAG_L);
  localparam logic [OUT_W-1:0] OUT_MAX = '1;
  localparam logic [3:0] LAST_STEP = 4'd9;
  localparam logic [3:0] CTR_STEP  = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_INIT  = 3'b010,
    ST_RELAX = 3'b100
  } state_t;

  // configuration registers
  logic [8:0]  grid_width_r;
  logic [7:0]  grid_height_r;
  logic [7:0]  threshold_r;
  logic [15:0] scale_r;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      threshold_r   <= THRESHOLD_RST;
      scale_r       <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[8:0];
        REG_GRID_HEIGHT: grid_height_r <= pwdata[7:0];
        REG_THRESHOLD:   threshold_r   <= pwdata[7:0];
        REG_SCALE:       scale_r       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_GRID_WIDTH:  prdata = {23'd0, grid_width_r};
      REG_GRID_HEIGHT: prdata = {24'd0, grid_height_r};
      REG_THRESHOLD:   prdata = {24'd0, threshold_r};
      REG_SCALE:       prdata = {16'd0, scale_r};
      default:         prdata = 32'd0;
    endcase
  end

  // grid size in use
  logic [WW-1:0] used_w;
  logic [HW-1:0] used_h;
  logic [CW-1:0] count;
  logic [LW-1:0] limit;
  logic [DW-1:0] start_dist;

  always_comb begin
    if (grid_width_r == 9'd0)             used_w = WW'(1);
    else if (int'(grid_width_r) > MAX_WIDTH) used_w = WW'(MAX_WIDTH);
    else                                   used_w = WW'(grid_width_r);
    if (grid_height_r == 8'd0)              used_h = HW'(1);
    else if (int'(grid_height_r) > MAX_HEIGHT) used_h = HW'(MAX_HEIGHT);
    else                                     used_h = HW'(grid_height_r);
  end

  assign count      = CW'(used_w) * CW'(used_h);
  assign limit      = LW'(used_w) + LW'(used_h);
  assign start_dist = DW'(limit) << FRAC_BITS;

  // control state
  state_t        st_r, st_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [LW-1:0] pass_r, pass_nxt;
  logic          changed_r, changed_nxt;
  logic [CW-1:0] load_ptr_r, load_ptr_nxt;
  logic [CW-1:0] read_ptr_r, read_ptr_nxt;
  logic          seed_r, seed_nxt;
  logic [DW:0]   best_r, best_nxt;
  logic          rd_v_r;
  logic          rd_last_r;

  // memories
  logic          water_mem [CELLS];
  logic [DW-1:0] dist_mem [CELLS];
  logic          wm_we;
  logic [AW-1:0] wm_addr;
  logic          wm_din;
  logic          dm_we;
  logic [DW-1:0] dm_din;
  logic [AW-1:0] rd_addr;
  logic          water_q;
  logic [DW-1:0] dist_q;

  logic          accept;
  logic          relaxing;
  logic [AW-1:0] ctr_addr;
  logic [AW-1:0] nb_addr;
  logic [AW-1:0] row_addr;
  logic [XW-1:0] col;
  nb_off_t       off_rd;
  nb_off_t       off_acc;
  logic [DW:0]   cand;
  logic          seed_fin;
  logic          upd;
  logic          row_end;
  logic          grid_end;
  logic [CW-1:0] ri;
  logic          ri_last;

  assign busy     = (st_r != ST_IDLE);
  assign accept   = start && !busy;
  assign relaxing = (st_r == ST_INIT) || (st_r == ST_RELAX);
  assign ctr_addr = base_r + AW'(x_r);

  // neighbour address with x wrap and y clamp
  always_comb begin
    off_rd = nb_offset(step_r);
    case (off_rd.dx)
      OFF_NEG: col = (x_r == '0) ? XW'(used_w - WW'(1)) : x_r - XW'(1);
      OFF_POS: col = (WW'(x_r) + WW'(1) >= used_w) ? '0 : x_r + XW'(1);
      default: col = x_r;
    endcase
    case (off_rd.dy)
      OFF_NEG: row_addr = (y_r == '0) ? base_r : base_r - AW'(used_w);
      OFF_POS: row_addr = (HW'(y_r) + HW'(1) >= used_h) ? base_r : base_r + AW'(used_w);
      default: row_addr = base_r;
    endcase
    nb_addr = row_addr + AW'(col);
  end

  // read pointer of the readout path
  assign ri      = (read_ptr_r >= count) ? '0 : read_ptr_r;
  assign ri_last = (ri + CW'(1) == count);

  assign rd_addr = relaxing ? nb_addr : ri[AW-1:0];

  // water map and distance store
  always_ff @(posedge clk) begin
    if (wm_we) water_mem[wm_addr] <= wm_din;
    water_q <= water_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dist_mem[ctr_addr] <= dm_din;
    dist_q <= dist_mem[rd_addr];
  end

  // window accumulation on the word read one step earlier
  always_comb begin
    off_acc  = nb_offset(step_r - 4'd1);
    cand     = {1'b0, dist_q} +
               (((off_acc.dx != OFF_ZERO) && (off_acc.dy != OFF_ZERO)) ? STEP_DG : STEP_AX);
    seed_fin = seed_r || !water_q;
    upd      = water_q && (best_r < {1'b0, dist_q});
    row_end  = (WW'(x_r) == used_w - WW'(1));
    grid_end = row_end && (HW'(y_r) == used_h - HW'(1));
  end

  // sequencer: load, readout, init pass and relaxation passes
  always_comb begin
    st_nxt       = st_r;
    step_nxt     = step_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    base_nxt     = base_r;
    pass_nxt     = pass_r;
    changed_nxt  = changed_r;
    load_ptr_nxt = load_ptr_r;
    read_ptr_nxt = read_ptr_r;
    seed_nxt     = seed_r;
    best_nxt     = best_r;
    wm_we        = 1'b0;
    wm_addr      = load_ptr_r[AW-1:0];
    wm_din       = (in_mask_value > threshold_r);
    dm_we        = 1'b0;
    dm_din       = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && !in_action) begin
          if (load_ptr_r < count) begin
            wm_we        = 1'b1;
            load_ptr_nxt = load_ptr_r + CW'(1);
          end
          if (in_load_last) begin
            st_nxt       = ST_INIT;
            step_nxt     = 4'd0;
            x_nxt        = '0;
            y_nxt        = '0;
            base_nxt     = '0;
            load_ptr_nxt = '0;
            read_ptr_nxt = '0;
          end
        end else if (accept) begin
          read_ptr_nxt = ri_last ? '0 : ri + CW'(1);
        end
      end
      ST_INIT, ST_RELAX: begin
        if (step_r == 4'd0) begin
          seed_nxt = 1'b0;
          best_nxt = '1;
        end else if (step_r <= CTR_STEP) begin
          seed_nxt = seed_r || !water_q;
          if (cand < best_r) best_nxt = cand;
        end
        if (step_r != LAST_STEP) begin
          step_nxt = step_r + 4'd1;
        end else begin
          step_nxt = 4'd0;
          if (st_r == ST_INIT) begin
            dm_we  = 1'b1;
            dm_din = seed_fin ? '0 : start_dist;
          end else if (upd) begin
            dm_we       = 1'b1;
            dm_din      = best_r[DW-1:0];
            changed_nxt = 1'b1;
          end
          if (row_end) begin
            x_nxt    = '0;
            y_nxt    = y_r + YW'(1);
            base_nxt = base_r + AW'(used_w);
          end else begin
            x_nxt = x_r + XW'(1);
          end
          if (grid_end) begin
            x_nxt       = '0;
            y_nxt       = '0;
            base_nxt    = '0;
            changed_nxt = 1'b0;
            if (st_r == ST_INIT) begin
              st_nxt   = ST_RELAX;
              pass_nxt = LW'(1);
            end else if (!(changed_r || upd) || (pass_r == limit)) begin
              st_nxt = ST_IDLE;
            end else begin
              pass_nxt = pass_r + LW'(1);
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      step_r     <= 4'd0;
      x_r        <= '0;
      y_r        <= '0;
      base_r     <= '0;
      pass_r     <= '0;
      changed_r  <= 1'b0;
      load_ptr_r <= '0;
      read_ptr_r <= '0;
      rd_v_r     <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      step_r     <= step_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      base_r     <= base_nxt;
      pass_r     <= pass_nxt;
      changed_r  <= changed_nxt;
      load_ptr_r <= load_ptr_nxt;
      read_ptr_r <= read_ptr_nxt;
      rd_v_r     <= accept && in_action;
      out_strobe <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    seed_r    <= seed_nxt;
    best_r    <= best_nxt;
    rd_last_r <= ri_last;
  end

  // scale and saturate the word read out; land pixels read out as zero
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;

  assign prod    = PW'(dist_q) * PW'(scale_r);
  assign shifted = prod >> FRAC_BITS;

  always_ff @(posedge clk) begin
    out_water_flag <= water_q;
    out_read_last  <= rd_last_r;
    if (!water_q)                     out_shore_distance <= '0;
    else if (shifted > PW'(OUT_MAX))  out_shore_distance <= OUT_MAX;
    else                              out_shore_distance <= shifted[OUT_W-1:0];
  end

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP) else $error("window step out of range");
  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    dm_we |-> (relaxing && step_r == LAST_STEP)) else $error("distance write off slot");
  a_land_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_water_flag) |-> (out_shore_distance == '0))
    else $error("land pixel with nonzero distance");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept && in_action, 2)) else $error("result without read word");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wm_we |-> !busy) else $error("mask write while relaxing");

endmodule
